// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition that never holds
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/exlex_pkg.sv =====
`default_nettype none
package exlex_pkg;
    localparam int MAX_NAME_DEF = 8;
    localparam int NAMES_DEF    = 16;
    localparam int KEYWORDS_DEF = 8;
    localparam int KW_COUNT     = 8;

    localparam logic [30:0] MANT_MAX  = 31'h7FFF_FFFF;
    localparam logic [3:0]  FRAC_MAX  = 4'd10;

    localparam logic [2:0] KIND_OP   = 3'd0;
    localparam logic [2:0] KIND_FUNC = 3'd1;
    localparam logic [2:0] KIND_VAR  = 3'd2;
    localparam logic [2:0] KIND_NUM  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    localparam logic [1:0] ERR_BAD_CHAR = 2'd0;
    localparam logic [1:0] ERR_NUM_BIG  = 2'd1;
    localparam logic [1:0] ERR_NAME_LONG = 2'd2;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd3;

    localparam int TOKEN_W = 51;

    typedef struct packed {
        logic        last_of_run;
        logic [1:0]  error_code;
        logic [3:0]  fraction_digits;
        logic [30:0] number_mantissa;
        logic [3:0]  variable_index;
        logic [2:0]  function_index;
        logic [2:0]  operator_code;
        logic [2:0]  token_kind;
    } token_t;

    // finished work handed from the front to the back
    typedef enum logic [2:0] {
        JOB_NONE = 3'b001,
        JOB_NUM  = 3'b010,
        JOB_NAME = 3'b100
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;        // pending token, emitted first unless tail_first is set
        logic [63:0] name;
        logic [30:0] mantissa;
        logic [3:0]  frac;
        logic        has_tail;    // a direct token follows
        logic        tail_first;  // direct token goes out ahead of the name
        logic        eot;         // byte marked end of text
        token_t      tail;
    } job_t;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_INT  = 5'b00010,
        MODE_FRAC = 5'b00100,
        MODE_NAME = 5'b01000,
        MODE_DROP = 5'b10000
    } mode_t;

    function automatic token_t make_tok(logic [2:0] kind);
        token_t t;
        t = '0;
        t.token_kind = kind;
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/exlex_front.sv =====
`default_nettype none
module exlex_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          character,
    input  wire logic                end_of_text,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output exlex_pkg::job_t          job
);
    import exlex_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [63:0] name_reg, name_next;
    logic [3:0]  len_reg, len_next;
    logic [30:0] mant_reg, mant_next;
    logic [3:0]  frac_reg, frac_next;
    job_t        j;
    logic        emit;

    logic        dig, let_c, spc, is_op, used;
    logic [2:0]  opc;
    logic [34:0] mul10;
    logic [3:0]  dval;
    mode_t       m;

    always_comb
    begin
        dig   = character >= 8'h30 && character <= 8'h39;
        let_c = (character >= 8'h41 && character <= 8'h5A) ||
                (character >= 8'h61 && character <= 8'h7A);
        spc   = character == 8'h20 || (character >= 8'h09 && character <= 8'h0D);
        dval  = character[3:0];
        is_op = 1'b1;
        opc   = 3'd0;
        case (character)
            8'h28: opc = 3'd0;
            8'h29: opc = 3'd1;
            8'h24: opc = 3'd2;
            8'h2B: opc = 3'd3;
            8'h2D: opc = 3'd4;
            8'h2F: opc = 3'd5;
            8'h2A: opc = 3'd6;
            8'h5E: opc = 3'd7;
            default: is_op = 1'b0;
        endcase
        mul10 = {mant_reg, 3'b000} + {2'b00, mant_reg, 1'b0} + {31'd0, dval};
    end

    always_comb
    begin
        m         = mode_reg;
        name_next = name_reg;
        len_next  = len_reg;
        mant_next = mant_reg;
        frac_next = frac_reg;
        used      = 1'b0;
        j         = '0;
        j.kind    = JOB_NONE;
        j.name    = name_reg;
        j.mantissa = mant_reg;
        j.frac    = frac_reg;
        j.eot     = end_of_text;
        if (m == MODE_INT || m == MODE_FRAC)
        begin
            used = 1'b1;
            if (dig)
            begin
                if (mul10 > {4'd0, MANT_MAX} || (m == MODE_FRAC && frac_reg >= FRAC_MAX))
                begin
                    j.has_tail = 1'b1;
                    j.tail = make_tok(KIND_ERR);
                    j.tail.error_code = ERR_NUM_BIG;
                    m = MODE_DROP;
                end
                else
                begin
                    mant_next = mul10[30:0];
                    if (m == MODE_FRAC)
                        frac_next = frac_reg + 4'd1;
                end
            end
            else if (character == 8'h2E && m == MODE_INT)
                m = MODE_FRAC;
            else
            begin
                used = 1'b0;
                j.kind = JOB_NUM;
                m = MODE_IDLE;
            end
        end
        else if (m == MODE_NAME)
        begin
            used = 1'b1;
            if (let_c || dig || character == 8'h5F)
            begin
                if (len_reg >= 4'(MAX_NAME_DEF))
                begin
                    j.has_tail = 1'b1;
                    j.tail = make_tok(KIND_ERR);
                    j.tail.error_code = ERR_NAME_LONG;
                    m = MODE_DROP;
                end
                else
                begin
                    name_next[len_reg[2:0]*8 +: 8] = character;
                    len_next = len_reg + 4'd1;
                end
            end
            else
            begin
                used = 1'b0;
                j.kind = JOB_NAME;
                m = MODE_IDLE;
            end
        end
        if (!used && m == MODE_IDLE)
        begin
            if (character == 8'h00)
                m = MODE_DROP;
            else if (spc)
                m = MODE_IDLE;
            else if (is_op)
            begin
                j.has_tail = 1'b1;
                j.tail = make_tok(KIND_OP);
                j.tail.operator_code = opc;
            end
            else if (dig)
            begin
                m = MODE_INT;
                mant_next = {27'd0, dval};
                frac_next = 4'd0;
            end
            else if (let_c)
            begin
                m = MODE_NAME;
                name_next = {56'd0, character};
                len_next = 4'd1;
            end
            else
            begin
                j.has_tail = 1'b1;
                j.tail = make_tok(KIND_ERR);
                j.tail.error_code = ERR_BAD_CHAR;
                m = MODE_DROP;
            end
        end
        if (end_of_text)
        begin
            // flush a pending token after the byte itself
            if (m == MODE_INT || m == MODE_FRAC)
            begin
                j.kind = JOB_NUM;
                j.mantissa = mant_next;
                j.frac = frac_next;
            end
            else if (m == MODE_NAME)
            begin
                if (j.kind == JOB_NUM)
                begin
                    // number ended by this letter goes out ahead of the name
                    j.has_tail = 1'b1;
                    j.tail_first = 1'b1;
                    j.tail = make_tok(KIND_NUM);
                    j.tail.number_mantissa = mant_reg;
                    j.tail.fraction_digits = frac_reg;
                end
                j.kind = JOB_NAME;
                j.name = name_next;
            end
            m = MODE_IDLE;
            name_next = '0;
            len_next = '0;
            mant_next = '0;
            frac_next = '0;
        end
        mode_next = m;
        // end of text always posts, so the back end can leave its drop state
        emit = j.kind != JOB_NONE || j.has_tail || end_of_text;
    end

    // a byte is held back only when it must post work and the queue is full
    assign in_ready  = job_ready || !emit;
    assign job_valid = in_valid && emit;
    assign job       = j;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            name_reg <= '0;
            len_reg  <= '0;
            mant_reg <= '0;
            frac_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            mode_reg <= mode_next;
            name_reg <= name_next;
            len_reg  <= len_next;
            mant_reg <= mant_next;
            frac_reg <= frac_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/exlex_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module exlex_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire exlex_pkg::job_t wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output exlex_pkg::job_t      rd_data
);
    import exlex_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    `ASSERT_NEVER(a_no_overfill, clk, rst_n, cnt_reg == 2'd3)
    `ASSERT_IMPL(a_ptr_match, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'd2, wp_reg == rp_reg)
    `ASSERT_IMPL(a_one_apart, clk, rst_n, cnt_reg == 2'd1, wp_reg != rp_reg)
endmodule
`default_nettype wire

// ===== hw/rtl/exlex_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module exlex_back
#(
    parameter int NAMES    = exlex_pkg::NAMES_DEF,
    parameter int KEYWORDS = exlex_pkg::KEYWORDS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [63:0]     keywords [exlex_pkg::KW_COUNT],
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  wire exlex_pkg::job_t job,
    output logic                 tok_valid,
    input  wire logic            tok_ready,
    output exlex_pkg::token_t    tok
);
    import exlex_pkg::*;

    localparam int IW = (NAMES > 1) ? $clog2(NAMES) : 1;
    localparam int CW = $clog2(NAMES + 1);

    // name table lives in flip-flops: searched in parallel each cycle
    logic [63:0] table_reg [NAMES];
    logic [CW-1:0] used_reg;
    logic        half_reg;   // first of two tokens already sent
    logic        out_v_reg;
    logic        drop_reg;   // table overflow, discard work up to end of text
    token_t      out_reg;

    token_t      lead, cur;
    logic        lead_on, lead_err, two, is_last, take, adv, skip, name_now;
    logic        kw_hit, nm_hit;
    logic [2:0]  kw_idx;
    logic [IW-1:0] nm_idx;
    logic        add_name;

    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = KEYWORDS - 1; i >= 0; i--)
            if (keywords[i] != 64'd0 && keywords[i] == job.name)
            begin
                kw_hit = 1'b1;
                kw_idx = 3'(i);
            end
        nm_hit = 1'b0;
        nm_idx = '0;
        for (int i = NAMES - 1; i >= 0; i--)
            if (CW'(i) < used_reg && table_reg[i] == job.name)
            begin
                nm_hit = 1'b1;
                nm_idx = IW'(i);
            end
        add_name = 1'b0;
        lead = '0;
        lead_on = job.kind != JOB_NONE;
        if (job.kind == JOB_NUM)
        begin
            lead = make_tok(KIND_NUM);
            lead.number_mantissa = job.mantissa;
            lead.fraction_digits = job.frac;
        end
        else if (job.kind == JOB_NAME)
        begin
            if (kw_hit)
            begin
                lead = make_tok(KIND_FUNC);
                lead.function_index = kw_idx;
            end
            else if (nm_hit)
            begin
                lead = make_tok(KIND_VAR);
                lead.variable_index = 4'(nm_idx);
            end
            else if (used_reg >= CW'(NAMES))
            begin
                lead = make_tok(KIND_ERR);
                lead.error_code = ERR_TABLE_FULL;
            end
            else
            begin
                lead = make_tok(KIND_VAR);
                lead.variable_index = 4'(used_reg);
                add_name = 1'b1;
            end
        end
        lead_err = lead_on && lead.token_kind == KIND_ERR;
        two = lead_on && job.has_tail && (job.tail_first || !lead_err);
        if (!half_reg)
            cur = (lead_on && !job.tail_first) ? lead : job.tail;
        else
            cur = job.tail_first ? lead : job.tail;
        name_now = job.tail_first ? half_reg : !half_reg;
        is_last = !two || half_reg;
        cur.last_of_run = is_last;
        skip = drop_reg || (!lead_on && !job.has_tail);
    end

    assign take = !out_v_reg || tok_ready;
    assign adv  = job_valid && take && !skip;
    assign job_ready = skip || (take && is_last);
    assign tok_valid = out_v_reg;
    assign tok = out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= cur;
        if (adv && name_now && add_name)
            table_reg[used_reg[IW-1:0]] <= job.name;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            half_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            if (take)
                out_v_reg <= job_valid && !skip;
            if (adv)
                half_reg <= !is_last;
            if (adv && name_now && add_name)
                used_reg <= used_reg + CW'(1);
            if (job_valid && job_ready && job.eot)
                drop_reg <= 1'b0;
            else if (adv && name_now && lead_err)
                drop_reg <= 1'b1;
        end
    end

    `ASSERT_NEVER(a_used_range, clk, rst_n, used_reg > CW'(NAMES))
    `ASSERT_IMPL(a_half_holds, clk, rst_n, half_reg, job_valid)
    `ASSERT_IMPL(a_stall_hold, clk, rst_n, out_v_reg && !tok_ready, ##1 out_v_reg)
endmodule
`default_nettype wire

// ===== hw/rtl/expression_lexer_with_name_interning.sv =====
// expression lexer with name interning
// s_axis: one text byte per transfer; tdata = character, tlast = end_of_text.
// m_axis: tokens; tdata from bit 0 = token_kind[3], operator_code[3],
//   function_index[3], variable_index[4], number_mantissa[31],
//   fraction_digits[4], error_code[2]; tlast = last_of_run (final token of a byte).
// cfg: cfg_valid/cfg_ready with cfg_index (0..7 keyword registers) and
//   cfg_data; write only while the stream is idle. cfg_ready is always high.
// throughput: one byte per cycle while the queue has room for the work it posts;
//   a byte that yields two tokens holds the back end until both have passed the
//   single token output register. A token goes through the queue write, then the
//   output register, before it is transferred. A pending number or name is
//   emitted when the byte that ends it arrives, ahead of that byte's own token.
// after a name table overflow the back end drops work up to the end of text.
// the name table is searched in parallel in flip-flops and emptied by reset;
// no clearing pass is needed. reset also clears keywords and lexer mode.
// when m_axis_tready is low, the output register and the two-entry queue fill,
// then s_axis_tready drops on the next byte that posts work; nothing is lost.
`default_nettype none
module expression_lexer_with_name_interning
#(
    parameter int NAMES    = exlex_pkg::NAMES_DEF,
    parameter int KEYWORDS = exlex_pkg::KEYWORDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // character[7:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // kind, op, func, var, mantissa, frac, err
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import exlex_pkg::*;

    logic [63:0] kw_reg [KW_COUNT];
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    job_t        fj, bj;
    token_t      tk;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KW_COUNT; i++)
                kw_reg[i] <= '0;
        end
        else if (cfg_valid)
            kw_reg[cfg_index] <= cfg_data;
    end

    exlex_front u_front
    (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .character(s_axis_tdata), .end_of_text(s_axis_tlast),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    exlex_queue u_queue
    (
        .clk, .rst_n,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    exlex_back #(.NAMES(NAMES), .KEYWORDS(KEYWORDS)) u_back
    (
        .clk, .rst_n, .keywords(kw_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .tok_valid(m_axis_tvalid), .tok_ready(m_axis_tready), .tok(tk)
    );

    assign m_axis_tdata = {6'd0, tk.error_code, tk.fraction_digits, tk.number_mantissa,
                           tk.variable_index, tk.function_index, tk.operator_code,
                           tk.token_kind};
    assign m_axis_tlast = tk.last_of_run;
endmodule
`default_nettype wire

// ===== test/expression_lexer_with_name_interning_tb.sv =====
module expression_lexer_with_name_interning_tb;
    import exlex_pkg::*;

    localparam int NAME_SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] OP_OPEN = 3'd0, OP_CLOSE = 3'd1, OP_END = 3'd2, OP_ADD = 3'd3;
    localparam logic [2:0] OP_SUB = 3'd4, OP_DIV = 3'd5, OP_MUL = 3'd6, OP_POW = 3'd7;

    typedef enum logic [2:0] {LX_IDLE, LX_INT, LX_FRAC, LX_NAME, LX_DROP} lex_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // character[7:0]
    logic        s_axis_tlast;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // token fields, token_kind lowest
    logic        m_axis_tlast;   // last_of_run
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    expression_lexer_with_name_interning u_dut (.*);

    // predictor state
    logic [63:0] kw_regs [8];
    logic [63:0] interned [NAME_SLOTS];
    int          interned_count;
    lex_mode_t   lx_mode;
    logic [63:0] name_acc;
    int          name_len;
    logic [30:0] mant_acc;
    logic [3:0]  frac_acc;

    token_t      token_queue [$];
    token_t      step_tokens [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          idle_cycles;
    bit          failed;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL expression_lexer_with_name_interning");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // token checker
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = token_t'({m_axis_tlast, m_axis_tdata[49:0]});
            if (token_queue.size() == 0)
            begin
                $display("%0t unexpected token %h", $time, got);
                failed = 1;
            end
            else
            begin
                want = token_queue.pop_front();
                if (got !== want || m_axis_tdata[55:50] !== 6'd0)
                begin
                    $display("%0t token mismatch expected %h actual %h (tdata %h)",
                             $time, want, got, m_axis_tdata);
                    failed = 1;
                end
            end
        end
    end

    function automatic token_t tok(logic [2:0] kind);
        token_t t;
        t = '0;
        t.token_kind = kind;
        return t;
    endfunction

    function automatic void emit_error(logic [1:0] code);
        token_t t;
        t = tok(KIND_ERR);
        t.error_code = code;
        step_tokens.push_back(t);
        lx_mode = LX_DROP;
    endfunction

    function automatic void emit_number();
        token_t t;
        t = tok(KIND_NUM);
        t.number_mantissa = mant_acc;
        t.fraction_digits = frac_acc;
        step_tokens.push_back(t);
        lx_mode = LX_IDLE;
    endfunction

    function automatic void emit_name();
        token_t t;
        lx_mode = LX_IDLE;
        for (int i = 0; i < 8; i++)
            if (kw_regs[i] != 0 && kw_regs[i] == name_acc)
            begin
                t = tok(KIND_FUNC);
                t.function_index = 3'(i);
                step_tokens.push_back(t);
                return;
            end
        for (int i = 0; i < interned_count; i++)
            if (interned[i] == name_acc)
            begin
                t = tok(KIND_VAR);
                t.variable_index = 4'(i);
                step_tokens.push_back(t);
                return;
            end
        if (interned_count >= NAME_SLOTS)
        begin
            emit_error(ERR_TABLE_FULL);
            return;
        end
        interned[interned_count] = name_acc;
        t = tok(KIND_VAR);
        t.variable_index = 4'(interned_count);
        step_tokens.push_back(t);
        interned_count++;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic int operator_of(logic [7:0] c);
        case (c)
            "(": return OP_OPEN;
            ")": return OP_CLOSE;
            "$": return OP_END;
            "+": return OP_ADD;
            "-": return OP_SUB;
            "/": return OP_DIV;
            "*": return OP_MUL;
            "^": return OP_POW;
            default: return -1;
        endcase
    endfunction

    // works out the tokens caused by one character
    function automatic void lex_character(logic [7:0] c, bit eot);
        bit used;
        int oc;
        longint unsigned next;
        token_t t;
        used = 0;
        step_tokens.delete();
        if (lx_mode == LX_INT || lx_mode == LX_FRAC)
        begin
            if (is_digit(c))
            begin
                next = longint'(mant_acc) * 10 + (c - "0");
                if (next > 64'h7FFF_FFFF || (lx_mode == LX_FRAC && frac_acc >= 10))
                    emit_error(ERR_NUM_BIG);
                else
                begin
                    mant_acc = next[30:0];
                    if (lx_mode == LX_FRAC)
                        frac_acc++;
                end
                used = 1;
            end
            else if (c == "." && lx_mode == LX_INT)
            begin
                lx_mode = LX_FRAC;
                used = 1;
            end
            else
                emit_number();
        end
        else if (lx_mode == LX_NAME)
        begin
            if (is_letter(c) || is_digit(c) || c == "_")
            begin
                if (name_len >= 8)
                    emit_error(ERR_NAME_LONG);
                else
                begin
                    name_acc |= 64'(c) << (8 * name_len);
                    name_len++;
                end
                used = 1;
            end
            else
                emit_name();
        end
        if (!used && lx_mode == LX_IDLE)
        begin
            oc = operator_of(c);
            if (c == 0)
                lx_mode = LX_DROP;
            else if (c == " " || (c >= 9 && c <= 13))
                ;
            else if (oc >= 0)
            begin
                t = tok(KIND_OP);
                t.operator_code = 3'(oc);
                step_tokens.push_back(t);
            end
            else if (is_digit(c))
            begin
                lx_mode = LX_INT;
                mant_acc = 31'(c - "0");
                frac_acc = 0;
            end
            else if (is_letter(c))
            begin
                lx_mode = LX_NAME;
                name_acc = 64'(c);
                name_len = 1;
            end
            else
                emit_error(ERR_BAD_CHAR);
        end
        if (eot)
        begin
            if (lx_mode == LX_INT || lx_mode == LX_FRAC)
                emit_number();
            else if (lx_mode == LX_NAME)
                emit_name();
            lx_mode = LX_IDLE;
            name_acc = 0;
            name_len = 0;
            mant_acc = 0;
            frac_acc = 0;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1;
        foreach (step_tokens[i])
            token_queue.push_back(step_tokens[i]);
    endfunction

    // tvalid stays up after a transfer so that bytes can follow back to back
    task automatic send_character(logic [7:0] c, bit eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lex_character(c, eot);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_character(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_keyword(int idx, logic [63:0] value);
        cfg_valid <= 1;
        cfg_index <= 3'(idx);
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        kw_regs[idx] = value;
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pack_name(string s);
        logic [63:0] v;
        v = 0;
        for (int i = 0; i < s.len() && i < 8; i++)
            v |= 64'(s[i]) << (8 * i);
        return v;
    endfunction

    task automatic test_keywords_setup();
        write_keyword(0, pack_name("sin"));
        write_keyword(1, pack_name("cos"));
        write_keyword(2, pack_name("ln"));
        write_keyword(3, pack_name("exp"));
        write_keyword(4, pack_name("sqrt"));
        write_keyword(5, pack_name("tg"));
        write_keyword(6, pack_name("abcdefgh"));
        write_keyword(7, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_directed();
        send_text("(+-*/^)$");
        send_text(" \t\n\v\f\r3.25 x_1+sin(y)");
        send_text("2147483647 2147483648");
        send_text("1.0123456789 1.01234567891");
        send_text("abcdefgh abcdefghi");
        send_text("3. 4..5");
        send_text("x#y");
        send_character(8'hFF, 1);
        send_text("a");
        send_character(8'h00, 0);
        send_character("q", 1);
        send_text("sin cos ln exp sqrt tg");
    endtask

    task automatic test_other_keywords();
        drain();
        write_keyword(0, 0);
        write_keyword(1, pack_name("x"));
        write_keyword(7, pack_name("Zz_9"));
        send_text("sin x Zz_9 cos");
    endtask

    function automatic logic [7:0] random_name_char(bit first);
        int r;
        r = $urandom_range(first ? 1 : 3);
        case (r)
            0: return 8'("a" + $urandom_range(3));
            1: return 8'("A" + $urandom_range(25));
            2: return 8'("0" + $urandom_range(9));
            default: return "_";
        endcase
    endfunction

    function automatic string random_text();
        string s;
        string ops;
        int n;
        int k;
        logic [7:0] c;
        s = "";
        ops = "()$+-/*^";
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 30)
            begin
                s = {s, string'(random_name_char(1))};
                repeat ($urandom_range(k < 3 ? 9 : 2))
                    s = {s, string'(random_name_char(0))};
            end
            else if (k < 55)
            begin
                repeat ($urandom_range(1, k < 35 ? 11 : 4))
                    s = {s, string'(8'("0" + $urandom_range(9)))};
                if ($urandom_range(1))
                begin
                    s = {s, "."};
                    repeat ($urandom_range(k < 37 ? 11 : 3))
                        s = {s, string'(8'("0" + $urandom_range(9)))};
                end
            end
            else if (k < 85)
            begin
                c = ops[$urandom_range(7)];
                s = {s, string'(c)};
            end
            else if (k < 97)
                s = {s, " "};
            else
            begin
                c = 8'($urandom_range(1, 255));
                s = {s, string'(c)};
            end
        end
        return s;
    endfunction

    task automatic test_random_phase(int items);
        int sent;
        string s;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(19) == 0)
            begin
                // raw bytes, zero byte included
                repeat ($urandom_range(1, 6))
                begin
                    send_character(8'($urandom_range(255)), $urandom_range(3) == 0);
                    sent++;
                end
            end
            else
            begin
                s = random_text();
                send_text(s);
                sent += s.len();
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        failed = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (kw_regs[i])
            kw_regs[i] = 0;
        foreach (interned[i])
            interned[i] = 0;
        interned_count = 0;
        lx_mode = LX_IDLE;
        name_acc = 0;
        name_len = 0;
        mant_acc = 0;
        frac_acc = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 71;
        test_keywords_setup();
        test_directed();
        test_other_keywords();
        test_random_phase(450);
        drain();
        test_keywords_setup();
        send_idle_pct = 71;
        recv_idle_pct = 21;
        test_random_phase(450);
        drain();
        write_keyword(1, pack_name("cos"));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(450);
        drain();

        if (!failed)
            $display("PASS expression_lexer_with_name_interning");
        else
            $display("FAIL expression_lexer_with_name_interning");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/exlex_pkg.sv
hw/rtl/exlex_front.sv
hw/rtl/exlex_queue.sv
hw/rtl/exlex_back.sv
hw/rtl/expression_lexer_with_name_interning.sv
test/expression_lexer_with_name_interning_tb.sv
